// ----- rtl/vrs_pkg.sv -----
// Package for the variable record stack: sizes, codes, transaction and control types.
`timescale 1ns / 1ps
`default_nettype none
package vrs_pkg;

  localparam int STACK_BYTES = 1024;
  localparam int TAG_BYTES   = 8;
  localparam int MAX_RECORD  = 64;
  // Largest stored length that a pop or peek will honor.
  localparam int READ_CAP    = 64;

  localparam int ADDR_W    = $clog2(STACK_BYTES);
  localparam int PTR_W     = $clog2(STACK_BYTES + 1);
  localparam int LEN_W     = 7;
  localparam int USED_W    = 11;
  localparam int FIT_W     = ((PTR_W > 8) ? PTR_W : 8) + 1;
  localparam int TAG_IDX_W = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;

  localparam logic [2:0] KIND_PUSH  = 3'd0;
  localparam logic [2:0] KIND_POP   = 3'd1;
  localparam logic [2:0] KIND_PEEK  = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_CHECK = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] elem_length;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        data_out;
    logic              data_valid;
    logic              last_out;
    logic              stack_empty;
    logic [USED_W-1:0] used_bytes;
  } out_item_t;

  typedef struct packed {
    logic       push_byte;
    logic       push_clr;
    logic       top_clr;
    logic       tag_start;
    logic       tag_wr;
    logic       tag_commit;
    logic       res_set;
    logic [1:0] res_status;
    logic       tag_rd;
    logic       pop;
    logic       rec_setup;
    logic       out_load_res;
    logic       out_load_byte;
  } cmd_t;

  typedef struct packed {
    logic push_rej;
    logic fits;
    logic top_small;
    logic rec_zero;
    logic byte_last;
    logic tag_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/vrs_ctrl.sv -----
// Controller state machine for the variable record stack.
`timescale 1ns / 1ps
`default_nettype none
module vrs_ctrl
  import vrs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire sts_t     sts,
  output cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAG,
    S_RESP,
    S_LEN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.kind) inside
            KIND_PUSH: begin
              cmd.push_byte = 1'b1;
              if (in_data.last) begin
                if (sts.push_rej) begin
                  cmd.push_clr   = 1'b1;
                  cmd.res_set    = 1'b1;
                  cmd.res_status = STATUS_NO_ROOM;
                  state_nxt      = S_RESP;
                end else begin
                  cmd.tag_start = 1'b1;
                  state_nxt     = S_TAG;
                end
              end
            end
            KIND_POP, KIND_PEEK: begin
              cmd.push_clr = 1'b1;
              if (sts.top_small) begin
                cmd.top_clr    = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = STATUS_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                cmd.tag_rd = 1'b1;
                cmd.pop    = (in_data.kind == KIND_POP);
                state_nxt  = S_LEN;
              end
            end
            KIND_CLEAR: begin
              cmd.push_clr   = 1'b1;
              cmd.top_clr    = 1'b1;
              cmd.res_set    = 1'b1;
              cmd.res_status = STATUS_OK;
              state_nxt      = S_RESP;
            end
            KIND_CHECK: begin
              cmd.push_clr   = 1'b1;
              cmd.res_set    = 1'b1;
              cmd.res_status = sts.fits ? STATUS_OK : STATUS_NO_ROOM;
              state_nxt      = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_TAG: begin
        cmd.tag_wr = 1'b1;
        if (sts.tag_last) begin
          cmd.tag_commit = 1'b1;
          cmd.push_clr   = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = STATUS_OK;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load_res = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_LEN: begin
        cmd.rec_setup = 1'b1;
        if (sts.rec_zero) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = STATUS_OK;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load_byte = 1'b1;
          if (sts.byte_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vrs_dp.sv -----
// Datapath for the variable record stack: byte memory, pointers, push bookkeeping, output register.
`timescale 1ns / 1ps
`default_nettype none
module vrs_dp
  import vrs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire cmd_t     cmd,
  output sts_t          sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic [7:0] mem [STACK_BYTES];

  logic [PTR_W-1:0]     top_r, top_nxt;
  logic                 push_active_r, push_active_nxt;
  logic                 push_rej_r, push_rej_nxt;
  logic [LEN_W-1:0]     push_cnt_r, push_cnt_nxt;
  logic [LEN_W-1:0]     push_len_r, push_len_nxt;
  logic [TAG_IDX_W-1:0] tag_idx_r;
  logic [ADDR_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic [7:0]           rdata_r;
  logic                 is_pop_r;
  logic [LEN_W-1:0]     want_r, n_r, k_r;
  logic [1:0]           res_status_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [FIT_W-1:0] need, room;
  logic             fits;
  logic             first, rej_eff, byte_wr;
  logic [LEN_W-1:0] cnt_eff, len_eff;
  logic [PTR_W-1:0] tag_base, tag_at, rec_start;
  logic [LEN_W-1:0] stored_cap, stored, n_calc;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  // Space check against the current top.
  assign need = FIT_W'(in_data.elem_length) + FIT_W'(TAG_BYTES);
  assign room = FIT_W'(STACK_BYTES) - FIT_W'(top_r);
  assign fits = (need <= room);

  // The first byte of a record sets its length and acceptance.
  assign first   = !push_active_r;
  assign rej_eff = first ? ((in_data.elem_length > LEN_W'(MAX_RECORD)) || !fits)
                         : push_rej_r;
  assign cnt_eff = first ? '0 : push_cnt_r;
  assign len_eff = first ? in_data.elem_length : push_len_r;
  assign byte_wr = cmd.push_byte && !rej_eff && (cnt_eff < len_eff);

  assign tag_base = top_r + PTR_W'(push_cnt_r);
  assign tag_at   = top_r - PTR_W'(TAG_BYTES);

  // Clamp the stored length to the read window and to the bytes below the tag.
  assign stored_cap = (rdata_r > 8'(READ_CAP)) ? LEN_W'(READ_CAP) : LEN_W'(rdata_r);
  assign stored     = (FIT_W'(stored_cap) > FIT_W'(tag_at)) ? LEN_W'(tag_at) : stored_cap;
  assign rec_start  = tag_at - PTR_W'(stored);
  assign n_calc     = (stored < want_r) ? stored : want_r;

  assign wr_en   = byte_wr || cmd.tag_wr;
  assign wr_addr = cmd.tag_wr ? ADDR_W'(tag_base + PTR_W'(tag_idx_r))
                              : ADDR_W'(top_r + PTR_W'(cnt_eff));
  assign wr_data = cmd.tag_wr ? ((tag_idx_r == '0) ? 8'(push_cnt_r) : 8'd0)
                              : in_data.data_byte;

  always_comb begin
    if (cmd.tag_rd) begin
      rd_addr_nxt = ADDR_W'(tag_at);
    end else if (cmd.rec_setup) begin
      rd_addr_nxt = ADDR_W'(rec_start);
    end else if (cmd.out_load_byte) begin
      rd_addr_nxt = rd_addr_r + ADDR_W'(1);
    end else begin
      rd_addr_nxt = rd_addr_r;
    end
  end

  always_comb begin
    top_nxt = top_r;
    if (cmd.top_clr) begin
      top_nxt = '0;
    end else if (cmd.tag_commit) begin
      top_nxt = tag_base + PTR_W'(TAG_BYTES);
    end else if (cmd.rec_setup && is_pop_r) begin
      top_nxt = rec_start;
    end
  end

  always_comb begin
    push_active_nxt = push_active_r;
    push_rej_nxt    = push_rej_r;
    push_cnt_nxt    = push_cnt_r;
    push_len_nxt    = push_len_r;
    if (cmd.push_clr) begin
      push_active_nxt = 1'b0;
      push_rej_nxt    = 1'b0;
      push_cnt_nxt    = '0;
      push_len_nxt    = '0;
    end else if (cmd.push_byte) begin
      push_active_nxt = 1'b1;
      push_rej_nxt    = rej_eff;
      push_cnt_nxt    = cnt_eff + LEN_W'(byte_wr);
      push_len_nxt    = len_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r         <= '0;
      push_active_r <= 1'b0;
      push_rej_r    <= 1'b0;
      push_cnt_r    <= '0;
      push_len_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      top_r         <= top_nxt;
      push_active_r <= push_active_nxt;
      push_rej_r    <= push_rej_nxt;
      push_cnt_r    <= push_cnt_nxt;
      push_len_r    <= push_len_nxt;
      if (cmd.out_load_res || cmd.out_load_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    if (cmd.tag_start) begin
      tag_idx_r <= '0;
    end else if (cmd.tag_wr) begin
      tag_idx_r <= tag_idx_r + TAG_IDX_W'(1);
    end
    if (cmd.tag_rd) begin
      is_pop_r <= cmd.pop;
      want_r   <= in_data.elem_length;
    end
    if (cmd.rec_setup) begin
      n_r <= n_calc;
      k_r <= '0;
    end else if (cmd.out_load_byte) begin
      k_r <= k_r + LEN_W'(1);
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
    end
    // Empty flag and used count reflect the top after this transaction's update.
    if (cmd.out_load_res) begin
      out_r.status      <= res_status_r;
      out_r.data_out    <= 8'd0;
      out_r.data_valid  <= 1'b0;
      out_r.last_out    <= 1'b1;
      out_r.stack_empty <= (top_r == '0);
      out_r.used_bytes  <= USED_W'(top_r);
    end else if (cmd.out_load_byte) begin
      out_r.status      <= STATUS_OK;
      out_r.data_out    <= rdata_r;
      out_r.data_valid  <= 1'b1;
      out_r.last_out    <= sts.byte_last;
      out_r.stack_empty <= (top_r == '0);
      out_r.used_bytes  <= USED_W'(top_r);
    end
  end

  assign sts.push_rej  = rej_eff;
  assign sts.fits      = fits;
  assign sts.top_small = (top_r < PTR_W'(TAG_BYTES));
  assign sts.rec_zero  = (n_calc == '0);
  assign sts.byte_last = (k_r == n_r - LEN_W'(1));
  assign sts.tag_last  = (tag_idx_r == TAG_IDX_W'(TAG_BYTES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- rtl/variable_record_stack.sv -----
// Top level of the variable record stack: controller and datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   in       | in_valid / in_ready  | in_data  (kind, byte, length, last)
//   out      | out_valid / out_ready| out_data (status, byte, flags, used)
//
// A push byte is taken in S_IDLE; the last byte of an accepted record enters S_TAG
// to write the length tag through the single memory write port, then S_RESP to hand
// over the status. Clear and space check go straight to S_RESP. Pop and peek fetch the
// tag, set up in S_LEN, then give one byte per cycle in S_EMIT while the output is free.
// Reset clears top pointer and control; memory stays undefined, no clearing pass.
// A result held by out_ready low stalls the controller; push bytes that give no
// result are still taken while an earlier result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module variable_record_stack
  import vrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  vrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- dv/variable_record_stack_tb.sv -----
// Self-checking testbench for the variable record stack: directed table, then random traffic.
`timescale 1ns / 1ps
module variable_record_stack_tb;
  import vrs_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_EVERY  = 150;
  localparam int TAIL_CYCLES  = 4 * TAG_BYTES + 16;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int MAX_LEN_CODE = (1 << LEN_W) - 1;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_BURSTY} rx_mode_e;

  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t reply;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{'{KIND_POP,   8'h00, 7'd1,   1'b0}, 1'b1, '{STATUS_EMPTY,   8'h00, 1'b0, 1'b1, 1'b1, 11'd0}},
    '{'{KIND_PEEK,  8'h00, 7'd127, 1'b0}, 1'b1, '{STATUS_EMPTY,   8'h00, 1'b0, 1'b1, 1'b1, 11'd0}},
    '{'{KIND_CHECK, 8'hFF, 7'd127, 1'b1}, 1'b1, '{STATUS_OK,      8'h00, 1'b0, 1'b1, 1'b1, 11'd0}},
    '{'{KIND_PUSH,  8'h00, 7'd0,   1'b1}, 1'b1, '{STATUS_OK,      8'h00, 1'b0, 1'b1, 1'b0, 11'd8}},
    '{'{KIND_PEEK,  8'h00, 7'd5,   1'b0}, 1'b1, '{STATUS_OK,      8'h00, 1'b0, 1'b1, 1'b0, 11'd8}},
    '{'{KIND_PUSH,  8'h00, 7'd3,   1'b0}, 1'b0, '0},
    '{'{KIND_PUSH,  8'hFF, 7'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_PUSH,  8'hA5, 7'd3,   1'b1}, 1'b1, '{STATUS_OK,      8'h00, 1'b0, 1'b1, 1'b0, 11'd19}},
    '{'{KIND_PEEK,  8'h00, 7'd127, 1'b0}, 1'b0, '0},
    '{'{KIND_POP,   8'h00, 7'd2,   1'b0}, 1'b0, '0},
    '{'{KIND_PUSH,  8'h5A, 7'd65,  1'b1}, 1'b1, '{STATUS_NO_ROOM, 8'h00, 1'b0, 1'b1, 1'b0, 11'd8}},
    '{'{KIND_PUSH,  8'hFF, 7'd127, 1'b1}, 1'b1, '{STATUS_NO_ROOM, 8'h00, 1'b0, 1'b1, 1'b0, 11'd8}},
    '{'{KIND_PUSH,  8'h11, 7'd10,  1'b0}, 1'b0, '0},
    '{'{KIND_PUSH,  8'h22, 7'd10,  1'b1}, 1'b0, '0},
    '{'{KIND_PUSH,  8'h33, 7'd1,   1'b0}, 1'b0, '0},
    '{'{KIND_PUSH,  8'h44, 7'd1,   1'b0}, 1'b0, '0},
    '{'{KIND_PUSH,  8'h55, 7'd1,   1'b1}, 1'b0, '0},
    '{'{KIND_PUSH,  8'h66, 7'd4,   1'b0}, 1'b0, '0},
    '{'{KIND_CHECK, 8'h00, 7'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_POP,   8'h00, 7'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_SPARE_HI, 8'hFF, 7'd127, 1'b1}, 1'b0, '0},
    '{'{KIND_SPARE_LO, 8'h00, 7'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_CLEAR, 8'h00, 7'd0,   1'b0}, 1'b1, '{STATUS_OK,      8'h00, 1'b0, 1'b1, 1'b1, 11'd0}},
    '{'{KIND_POP,   8'h00, 7'd64,  1'b0}, 1'b1, '{STATUS_EMPTY,   8'h00, 1'b0, 1'b1, 1'b1, 11'd0}}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow of the stack contents and the open record.
  logic [7:0]  shadow_mem [STACK_BYTES];
  int unsigned fill = 0;
  bit          rec_open = 1'b0;
  bit          rec_drop = 1'b0;
  int unsigned rec_got = 0;
  int unsigned rec_want = 0;

  out_item_t   due_replies [$];
  out_item_t   step_replies [$];
  out_item_t   oldest_reply;
  int          mismatches = 0;
  int unsigned stack_items = 0;
  int unsigned burst_left = 0;
  int          cycles = 0;

  rx_mode_e    rx_mode = RX_STREAM;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold = 0;

  variable_record_stack u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit room_for(int unsigned len);
    return len + TAG_BYTES <= STACK_BYTES - fill;
  endfunction

  function automatic void add_reply(logic [1:0] status, logic [7:0] data, logic valid,
                                    logic fin);
    out_item_t r;
    r.status      = status;
    r.data_out    = data;
    r.data_valid  = valid;
    r.last_out    = fin;
    r.stack_empty = (fill == 0);
    r.used_bytes  = USED_W'(fill);
    step_replies.push_back(r);
  endfunction

  // Apply one transaction to the shadow stack and collect the replies it causes.
  function automatic void advance_stack(in_item_t it);
    int unsigned stored, tag_at, start, n;
    step_replies.delete();
    if (it.kind == KIND_PUSH) begin
      if (!rec_open) begin
        rec_open = 1'b1;
        rec_got  = 0;
        rec_want = it.elem_length;
        rec_drop = (rec_want > MAX_RECORD) || !room_for(rec_want);
      end
      if (!rec_drop && rec_got < rec_want) begin
        shadow_mem[fill + rec_got] = it.data_byte;
        rec_got++;
      end
      if (it.last) begin
        if (!rec_drop) begin
          // tag holds the count actually received
          shadow_mem[fill + rec_got] = 8'(rec_got);
          for (int i = 1; i < TAG_BYTES; i++) shadow_mem[fill + rec_got + i] = 8'h00;
          fill = fill + rec_got + TAG_BYTES;
        end
        add_reply(rec_drop ? STATUS_NO_ROOM : STATUS_OK, 8'h00, 1'b0, 1'b1);
        rec_open = 1'b0;
      end
    end else if (it.kind <= KIND_CHECK) begin
      // drop any unfinished record
      rec_open = 1'b0;
      if (it.kind == KIND_CLEAR) begin
        fill = 0;
        add_reply(STATUS_OK, 8'h00, 1'b0, 1'b1);
      end else if (it.kind == KIND_CHECK) begin
        add_reply(room_for(it.elem_length) ? STATUS_OK : STATUS_NO_ROOM, 8'h00, 1'b0, 1'b1);
      end else if (fill < TAG_BYTES) begin
        fill = 0;
        add_reply(STATUS_EMPTY, 8'h00, 1'b0, 1'b1);
      end else begin
        tag_at = fill - TAG_BYTES;
        stored = shadow_mem[tag_at];
        if (stored > READ_CAP) stored = READ_CAP;
        if (stored > tag_at) stored = tag_at;
        start = tag_at - stored;
        n = (stored < it.elem_length) ? stored : it.elem_length;
        if (it.kind == KIND_POP) fill = start;
        if (n == 0) add_reply(STATUS_OK, 8'h00, 1'b0, 1'b1);
        for (int unsigned k = 0; k < n; k++)
          add_reply(STATUS_OK, shadow_mem[start + k], 1'b1, k + 1 == n);
      end
    end
  endfunction

  // Length that lands on the edge of the free space, or one past it.
  function automatic int unsigned fit_edge_len();
    int unsigned room;
    room = STACK_BYTES - fill;
    if (room < TAG_BYTES) return $urandom_range(0, 2);
    return room - TAG_BYTES + $urandom_range(0, 1);
  endfunction

  task automatic drive_item(in_item_t it, logic fixed, out_item_t reply);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    advance_stack(it);
    if (fixed) begin
      due_replies.push_back(reply);
    end else begin
      foreach (step_replies[i]) due_replies.push_back(step_replies[i]);
    end
    if (it.kind <= KIND_CHECK) stack_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic send_command();
    in_item_t    it;
    int unsigned sel, len;
    sel = $urandom_range(0, 99);
    it.kind = (sel < 40) ? KIND_POP : (sel < 65) ? KIND_PEEK :
              (sel < 95) ? KIND_CHECK : KIND_CLEAR;
    it.data_byte = 8'($urandom_range(0, 255));
    it.last      = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (it.kind == KIND_CHECK && sel < 40) len = fit_edge_len();
    else if (sel < 50) len = $urandom_range(0, 8);
    else if (sel < 80) len = $urandom_range(9, MAX_RECORD);
    else len = $urandom_range(MAX_RECORD + 1, MAX_LEN_CODE);
    if (len > MAX_LEN_CODE) len = MAX_LEN_CODE;
    it.elem_length = LEN_W'(len);
    drive_item(it, 1'b0, '0);
  endtask

  task automatic send_record(bit filling);
    in_item_t    it;
    int unsigned len, count, sel;
    bit          cut;
    sel = $urandom_range(0, 99);
    if (filling && sel < 70) begin
      len = $urandom_range(0, 2);
    end else if (sel < 80) begin
      len = $urandom_range(0, MAX_RECORD);
    end else if (sel < 90) begin
      len = fit_edge_len();
      if (len > MAX_RECORD + 1) len = MAX_RECORD;
    end else begin
      len = $urandom_range(MAX_RECORD + 1, MAX_LEN_CODE);
    end
    count = (len == 0) ? 1 : len;
    sel = $urandom_range(0, 99);
    if (len > MAX_RECORD) count = $urandom_range(1, 4);
    else if (sel >= 90) count = count + $urandom_range(1, 3);
    else if (sel >= 80 && len > 1) count = $urandom_range(1, len - 1);
    cut = ($urandom_range(0, 19) == 0);
    for (int unsigned k = 0; k < count; k++) begin
      it.kind        = KIND_PUSH;
      it.data_byte   = 8'($urandom_range(0, 255));
      it.elem_length = (k == 0) ? LEN_W'(len) : LEN_W'($urandom_range(0, MAX_LEN_CODE));
      it.last        = !cut && (k + 1 == count);
      drive_item(it, 1'b0, '0);
    end
    // abandon the record with a command
    if (cut) send_command();
  endtask

  task automatic match_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_replies.size() == 0) begin
        $error("reply with nothing due: status %0d data %0d used %0d",
               out_data.status, out_data.data_out, out_data.used_bytes);
        mismatches++;
      end else begin
        oldest_reply = due_replies.pop_front();
        match_field("status", oldest_reply.status, out_data.status);
        match_field("data_out", oldest_reply.data_out, out_data.data_out);
        match_field("data_valid", oldest_reply.data_valid, out_data.data_valid);
        match_field("last_out", oldest_reply.last_out, out_data.last_out);
        match_field("stack_empty", oldest_reply.stack_empty, out_data.stack_empty);
        match_field("used_bytes", oldest_reply.used_bytes, out_data.used_bytes);
      end
    end
  end

  // Receiver: switch between streaming, coin-flip and bursty stall modes.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(32, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_hold   <= $urandom_range(1, 8);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t    spare;
    bit          filling;
    int unsigned next_drain, pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < PLAN_ROWS; r++) drive_item(PLAN[r].item, PLAN[r].fixed, PLAN[r].reply);
    wait_drained();
    stack_items = 0;
    filling = 1'b1;
    next_drain = DRAIN_EVERY;
    while (stack_items < RANDOM_ITEMS) begin
      // fill until nearly full, then drain back down
      if (filling && STACK_BYTES - fill < 2 * TAG_BYTES) filling = 1'b0;
      else if (!filling && fill < STACK_BYTES / 8) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        spare.kind        = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        spare.data_byte   = 8'($urandom_range(0, 255));
        spare.elem_length = LEN_W'($urandom_range(0, MAX_LEN_CODE));
        spare.last        = 1'($urandom_range(0, 1));
        drive_item(spare, 1'b0, '0);
      end else if (pick < (filling ? 85 : 20)) begin
        send_record(filling);
      end else begin
        send_command();
      end
      if (stack_items >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
